[src/range_scan_deepest_gap_finder_unit_macros.svh]
// ---------------------------------------------------------------------------
// Range scan deepest gap finder - assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef RANGE_SCAN_DEEPEST_GAP_FINDER_UNIT_MACROS_SVH
`define RANGE_SCAN_DEEPEST_GAP_FINDER_UNIT_MACROS_SVH

// same-cycle implication
`define RSDG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSDG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rsdg_pkg.sv]
// ---------------------------------------------------------------------------
// Range scan deepest gap finder - package
// Sizes, constants, register map and payload types.
// ---------------------------------------------------------------------------
package rsdg_pkg;

    localparam int MaxBeams  = 2048;
    localparam int IdxW      = $clog2(MaxBeams);
    localparam int RangeW    = 16;
    localparam int MinWidthW = 12;
    localparam int CmpW      = (IdxW + 1 > MinWidthW) ? IdxW + 1 : MinWidthW;
    localparam int AddrW     = 3;
    localparam int DataW     = 32;

    localparam logic [RangeW-1:0]    FreeMinMm       = 16'd100;
    localparam logic [IdxW-1:0]      LastIdx         = IdxW'(MaxBeams - 1);
    localparam logic [MinWidthW-1:0] MinGapWidthRst  = 12'd10;
    localparam logic [RangeW-1:0]    MaxRangeMmRst   = 16'd30000;

    typedef enum logic [0:0] {
        RegMinGapWidth = 1'b0,
        RegMaxRangeMm  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [MinWidthW-1:0] min_gap_width;
        logic [RangeW-1:0]    max_range_mm;
    } cfg_t;

    typedef struct packed {
        logic [RangeW-1:0] range_mm;
        logic              last_beam;
    } beam_t;

    typedef struct packed {
        logic              gap_found;
        logic [IdxW-1:0]   gap_first;
        logic [IdxW-1:0]   gap_last;
        logic [IdxW-1:0]   deepest_beam;
        logic [RangeW-1:0] deepest_range;
    } gap_t;

endpackage

[src/rsdg_if.sv]
// ---------------------------------------------------------------------------
// Range scan deepest gap finder - channel interfaces
// Beam request channel and gap result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface rsdg_beam_if;
    import rsdg_pkg::*;

    logic              valid;
    logic              ready;
    logic [RangeW-1:0] range_mm;
    logic              last_beam;

    modport source (output valid, output range_mm, output last_beam, input ready);
    modport sink (input valid, input range_mm, input last_beam, output ready);
endinterface

interface rsdg_gap_if;
    import rsdg_pkg::*;

    logic              valid;
    logic              ready;
    logic              gap_found;
    logic [IdxW-1:0]   gap_first;
    logic [IdxW-1:0]   gap_last;
    logic [IdxW-1:0]   deepest_beam;
    logic [RangeW-1:0] deepest_range;

    modport source (
        output valid, output gap_found, output gap_first, output gap_last,
        output deepest_beam, output deepest_range, input ready
    );
    modport sink (
        input valid, input gap_found, input gap_first, input gap_last,
        input deepest_beam, input deepest_range, output ready
    );
endinterface

[src/rsdg_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Range scan deepest gap finder - configuration registers
// APB-style register file holding minimum gap width and maximum free range.
// ---------------------------------------------------------------------------
module rsdg_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rsdg_pkg::AddrW-1:0] paddr,
    input  logic [rsdg_pkg::DataW-1:0] pwdata,
    output logic [rsdg_pkg::DataW-1:0] prdata,
    output logic                      pready,
    output rsdg_pkg::cfg_t            cfg
);
    import rsdg_pkg::*;

    logic [MinWidthW-1:0] min_gap_width_reg;
    logic [RangeW-1:0]    max_range_mm_reg;
    logic                 wr_en;
    reg_idx_t             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_width_reg <= MinGapWidthRst;
            max_range_mm_reg  <= MaxRangeMmRst;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                RegMinGapWidth: min_gap_width_reg <= pwdata[MinWidthW-1:0];
                RegMaxRangeMm:  max_range_mm_reg  <= pwdata[RangeW-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            RegMinGapWidth: prdata = DataW'(min_gap_width_reg);
            RegMaxRangeMm:  prdata = DataW'(max_range_mm_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.min_gap_width = min_gap_width_reg;
    assign cfg.max_range_mm  = max_range_mm_reg;
endmodule

[src/rsdg_in_stage.sv]
// ---------------------------------------------------------------------------
// Range scan deepest gap finder - input register
// Captures one beam request and holds it until the tracker advances.
// ---------------------------------------------------------------------------
module rsdg_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    rsdg_beam_if.sink         beam,
    input  logic              advance,
    output logic              stage_valid,
    output rsdg_pkg::beam_t   stage_beam
);
    import rsdg_pkg::*;

    logic  valid_reg;
    beam_t beam_reg;
    logic  take;

    assign beam.ready = !valid_reg || advance;
    assign take       = beam.valid && beam.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (beam.ready)
        begin
            valid_reg <= beam.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beam_reg.range_mm  <= beam.range_mm;
            beam_reg.last_beam <= beam.last_beam;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_beam  = beam_reg;
endmodule

[src/rsdg_gap_tracker.sv]
// ---------------------------------------------------------------------------
// Range scan deepest gap finder - run and gap tracker
// Counts beams, follows runs of free beams and keeps the deepest gap.
// ---------------------------------------------------------------------------
`include "range_scan_deepest_gap_finder_unit_macros.svh"

module rsdg_gap_tracker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  rsdg_pkg::beam_t beam,
    input  rsdg_pkg::cfg_t  cfg,
    output logic            result_valid,
    output rsdg_pkg::gap_t  result
);
    import rsdg_pkg::*;

    logic [IdxW-1:0]   beam_cnt_reg, beam_cnt_next;
    logic              in_run_reg, in_run_next;
    logic [IdxW-1:0]   run_start_reg, run_start_next;
    logic [IdxW-1:0]   run_best_index_reg, run_best_index_next;
    logic [RangeW-1:0] run_best_range_reg, run_best_range_next;
    logic              have_best_reg, have_best_next;
    logic [IdxW-1:0]   best_first_reg, best_first_next;
    logic [IdxW-1:0]   best_last_reg, best_last_next;
    logic [IdxW-1:0]   best_index_reg, best_index_next;
    logic [RangeW-1:0] best_range_reg, best_range_next;

    logic              free_beam;
    logic [IdxW-1:0]   start_after;
    logic              run_grow;
    logic [IdxW-1:0]   best_index_after;
    logic [RangeW-1:0] best_range_after;
    logic              close_on_block;
    logic              close_on_last;
    logic [IdxW-1:0]   cand_start;
    logic [IdxW-1:0]   cand_end;
    logic [IdxW-1:0]   cand_index;
    logic [RangeW-1:0] cand_range;
    logic [CmpW-1:0]   cand_width;
    logic              qualify;
    logic              take;
    logic              found;

    always_comb
    begin
        free_beam = (beam.range_mm >= FreeMinMm) && (beam.range_mm <= cfg.max_range_mm);
        start_after = in_run_reg ? run_start_reg : beam_cnt_reg;
        run_grow = free_beam && (!in_run_reg || (beam.range_mm > run_best_range_reg));
        best_index_after = run_grow ? beam_cnt_reg : run_best_index_reg;
        best_range_after = run_grow ? beam.range_mm : run_best_range_reg;

        close_on_block = in_run_reg && !free_beam;
        close_on_last  = beam.last_beam && free_beam;

        cand_start = close_on_last ? start_after : run_start_reg;
        cand_end   = close_on_last ? beam_cnt_reg : beam_cnt_reg - 1'b1;
        cand_index = close_on_last ? best_index_after : run_best_index_reg;
        cand_range = close_on_last ? best_range_after : run_best_range_reg;
        cand_width = CmpW'(beam_cnt_reg) - CmpW'(cand_start) + CmpW'(close_on_last);

        qualify = (close_on_block || close_on_last)
                  && (cand_width >= CmpW'(cfg.min_gap_width));
        take    = qualify && (!have_best_reg || (cand_range > best_range_reg));

        have_best_next  = have_best_reg || take;
        best_first_next = take ? cand_start : best_first_reg;
        best_last_next  = take ? cand_end   : best_last_reg;
        best_index_next = take ? cand_index : best_index_reg;
        best_range_next = take ? cand_range : best_range_reg;

        in_run_next         = free_beam;
        run_start_next      = free_beam ? start_after : run_start_reg;
        run_best_index_next = best_index_after;
        run_best_range_next = best_range_after;
        beam_cnt_next       = (beam_cnt_reg < LastIdx) ? beam_cnt_reg + 1'b1 : beam_cnt_reg;

        found                = have_best_next;
        result_valid         = advance && beam.last_beam;
        result.gap_found     = found;
        result.gap_first     = found ? best_first_next : '0;
        result.gap_last      = found ? best_last_next  : '0;
        result.deepest_beam  = found ? best_index_next : '0;
        result.deepest_range = found ? best_range_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_cnt_reg       <= '0;
            in_run_reg         <= 1'b0;
            run_start_reg      <= '0;
            run_best_index_reg <= '0;
            run_best_range_reg <= '0;
            have_best_reg      <= 1'b0;
            best_first_reg     <= '0;
            best_last_reg      <= '0;
            best_index_reg     <= '0;
            best_range_reg     <= '0;
        end
        else if (advance && beam.last_beam)
        begin
            // drop all scan state after the closing beam
            beam_cnt_reg       <= '0;
            in_run_reg         <= 1'b0;
            run_start_reg      <= '0;
            run_best_index_reg <= '0;
            run_best_range_reg <= '0;
            have_best_reg      <= 1'b0;
            best_first_reg     <= '0;
            best_last_reg      <= '0;
            best_index_reg     <= '0;
            best_range_reg     <= '0;
        end
        else if (advance)
        begin
            beam_cnt_reg       <= beam_cnt_next;
            in_run_reg         <= in_run_next;
            run_start_reg      <= run_start_next;
            run_best_index_reg <= run_best_index_next;
            run_best_range_reg <= run_best_range_next;
            have_best_reg      <= have_best_next;
            best_first_reg     <= best_first_next;
            best_last_reg      <= best_last_next;
            best_index_reg     <= best_index_next;
            best_range_reg     <= best_range_next;
        end
    end

    `RSDG_ASSERT_NOW(a_empty_result_zero, result_valid && !result.gap_found, result.gap_first == '0 && result.gap_last == '0 && result.deepest_beam == '0 && result.deepest_range == '0, "empty result carries nonzero fields")
    `RSDG_ASSERT_NEXT(a_scan_cleared, advance && beam.last_beam, beam_cnt_reg == '0 && !in_run_reg && !have_best_reg, "scan state not cleared after last beam")
    `RSDG_ASSERT_NOW(a_run_start_order, in_run_reg, run_start_reg <= beam_cnt_reg && run_best_index_reg >= run_start_reg, "open run indices out of order")
endmodule

[src/range_scan_deepest_gap_finder_unit.sv]
// ---------------------------------------------------------------------------
// Range scan deepest gap finder - top level
// Streams lidar beams, tracks runs of free beams and reports the deepest gap
// of each scan on its last beam.
// ---------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  beam      in    valid / ready    range_mm, last_beam
//  gap       out   valid / ready    gap_found, gap_first, gap_last,
//                                   deepest_beam, deepest_range
//  apb       in    psel / penable   min_gap_width, max_range_mm
//
//  One beam per cycle unless a last beam waits on a held result: a beam is
//  registered, then updates the scan state; a scan's result is registered
//  in the output register as its last beam advances. Reset clears the scan
//  state and loads the register defaults. A result waiting in the output
//  register stalls only a later last beam; ordinary beams keep flowing.
// ---------------------------------------------------------------------------
`include "range_scan_deepest_gap_finder_unit_macros.svh"

module range_scan_deepest_gap_finder_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rsdg_pkg::AddrW-1:0] paddr,
    input  logic [rsdg_pkg::DataW-1:0] pwdata,
    output logic [rsdg_pkg::DataW-1:0] prdata,
    output logic                       pready,
    rsdg_beam_if.sink                  beam,
    rsdg_gap_if.source                 gap
);
    import rsdg_pkg::*;

    cfg_t  cfg;
    logic  stage_valid;
    beam_t stage_beam;
    logic  advance;
    logic  result_valid;
    gap_t  result;
    logic  out_valid_reg;
    gap_t  out_reg;

    rsdg_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rsdg_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .beam        (beam),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_beam  (stage_beam)
    );

    rsdg_gap_tracker u_gap_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .beam         (stage_beam),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result       (result)
    );

    // hold a last beam while the previous result is still waiting
    assign advance = stage_valid && (!stage_beam.last_beam || !out_valid_reg || gap.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (gap.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            out_reg <= result;
        end
    end

    assign gap.valid         = out_valid_reg;
    assign gap.gap_found     = out_reg.gap_found;
    assign gap.gap_first     = out_reg.gap_first;
    assign gap.gap_last      = out_reg.gap_last;
    assign gap.deepest_beam  = out_reg.deepest_beam;
    assign gap.deepest_range = out_reg.deepest_range;

    `RSDG_ASSERT_NEXT(a_last_beam_held, stage_valid && stage_beam.last_beam && out_valid_reg && !gap.ready, stage_valid && stage_beam.last_beam, "stalled last beam dropped")
    `RSDG_ASSERT_NOW(a_result_slot_free, result_valid, !out_valid_reg || gap.ready, "result overwrites a waiting result")
    `RSDG_ASSERT_NOW(a_plain_beam_flows, stage_valid && !stage_beam.last_beam, advance && beam.ready, "ordinary beam stalled")
endmodule
